/* sv/rcc_pkg.sv */
// Shared types, constants and codes of the crop and centroid core.
`default_nettype none

package rcc_pkg;

   localparam int DATA_BITS      = 32;
   localparam int COUNT_BITS     = 21;
   localparam int BOX_BITS       = 10;
   localparam int SIZE_BITS      = 11;
   localparam int CMP_BITS       = 13;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 11;

   localparam int DEF_MAX_COLUMNS = 1024;
   localparam int DEF_MAX_ROWS    = 1024;
   localparam int DEF_COORD_BITS  = 32;

   localparam logic [BOX_BITS-1:0]  BOX_LEFT_RESET   = BOX_BITS'(0);
   localparam logic [BOX_BITS-1:0]  BOX_TOP_RESET    = BOX_BITS'(0);
   localparam logic [BOX_BITS-1:0]  BOX_RIGHT_RESET  = BOX_BITS'(1);
   localparam logic [BOX_BITS-1:0]  BOX_BOTTOM_RESET = BOX_BITS'(1);
   localparam logic [SIZE_BITS-1:0] FRAME_SIZE_RESET = SIZE_BITS'(1024);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BOX_LEFT      = 3'd0,
      CSR_BOX_TOP       = 3'd1,
      CSR_BOX_RIGHT     = 3'd2,
      CSR_BOX_BOTTOM    = 3'd3,
      CSR_FRAME_COLUMNS = 3'd4,
      CSR_FRAME_ROWS    = 3'd5,
      CSR_KEEP_INSIDE   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_POINT    = 2'd0,
      KIND_CENTROID = 2'd1,
      KIND_ERROR    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_LOAD,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [BOX_BITS-1:0] box_left;
      logic [BOX_BITS-1:0] box_top;
      logic [BOX_BITS-1:0] box_right;
      logic [BOX_BITS-1:0] box_bottom;
      logic [CMP_BITS-1:0] columns;
      logic [CMP_BITS-1:0] rows;
      logic                keep_inside;
      logic                box_ok;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic div_start;
      logic cent_load;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic out_free;
      logic div_busy;
   } status_type;

endpackage

`default_nettype wire

/* sv/rcc_csr.sv */
// Configuration registers with clamped frame geometry and box check.
`default_nettype none

module rcc_csr #(
   parameter int MAX_COLUMNS = rcc_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = rcc_pkg::DEF_MAX_ROWS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [rcc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [rcc_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output rcc_pkg::cfg_type                        cfg
);
   import rcc_pkg::*;

   logic [BOX_BITS-1:0]  box_left_ff, box_left_in;
   logic [BOX_BITS-1:0]  box_top_ff, box_top_in;
   logic [BOX_BITS-1:0]  box_right_ff, box_right_in;
   logic [BOX_BITS-1:0]  box_bottom_ff, box_bottom_in;
   logic [SIZE_BITS-1:0] frame_columns_ff, frame_columns_in;
   logic [SIZE_BITS-1:0] frame_rows_ff, frame_rows_in;
   logic                 keep_inside_ff, keep_inside_in;
   logic [CMP_BITS-1:0]  columns_ext;
   logic [CMP_BITS-1:0]  rows_ext;
   logic [CMP_BITS-1:0]  columns_eff;
   logic [CMP_BITS-1:0]  rows_eff;

   assign csr_ready = 1'b1;

   always_comb begin
      box_left_in      = box_left_ff;
      box_top_in       = box_top_ff;
      box_right_in     = box_right_ff;
      box_bottom_in    = box_bottom_ff;
      frame_columns_in = frame_columns_ff;
      frame_rows_in    = frame_rows_ff;
      keep_inside_in   = keep_inside_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_BOX_LEFT:      box_left_in      = csr_data[BOX_BITS-1:0];
            CSR_BOX_TOP:       box_top_in       = csr_data[BOX_BITS-1:0];
            CSR_BOX_RIGHT:     box_right_in     = csr_data[BOX_BITS-1:0];
            CSR_BOX_BOTTOM:    box_bottom_in    = csr_data[BOX_BITS-1:0];
            CSR_FRAME_COLUMNS: frame_columns_in = csr_data[SIZE_BITS-1:0];
            CSR_FRAME_ROWS:    frame_rows_in    = csr_data[SIZE_BITS-1:0];
            CSR_KEEP_INSIDE:   keep_inside_in   = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_left_ff      <= BOX_LEFT_RESET;
         box_top_ff       <= BOX_TOP_RESET;
         box_right_ff     <= BOX_RIGHT_RESET;
         box_bottom_ff    <= BOX_BOTTOM_RESET;
         frame_columns_ff <= FRAME_SIZE_RESET;
         frame_rows_ff    <= FRAME_SIZE_RESET;
         keep_inside_ff   <= 1'b1;
      end else begin
         box_left_ff      <= box_left_in;
         box_top_ff       <= box_top_in;
         box_right_ff     <= box_right_in;
         box_bottom_ff    <= box_bottom_in;
         frame_columns_ff <= frame_columns_in;
         frame_rows_ff    <= frame_rows_in;
         keep_inside_ff   <= keep_inside_in;
      end
   end

   always_comb begin
      columns_ext = CMP_BITS'(frame_columns_ff);
      rows_ext    = CMP_BITS'(frame_rows_ff);
      priority if (columns_ext == '0) begin
         columns_eff = CMP_BITS'(1);
      end else if (columns_ext > CMP_BITS'(MAX_COLUMNS)) begin
         columns_eff = CMP_BITS'(MAX_COLUMNS);
      end else begin
         columns_eff = columns_ext;
      end
      priority if (rows_ext == '0) begin
         rows_eff = CMP_BITS'(1);
      end else if (rows_ext > CMP_BITS'(MAX_ROWS)) begin
         rows_eff = CMP_BITS'(MAX_ROWS);
      end else begin
         rows_eff = rows_ext;
      end
   end

   always_comb begin
      cfg.box_left    = box_left_ff;
      cfg.box_top     = box_top_ff;
      cfg.box_right   = box_right_ff;
      cfg.box_bottom  = box_bottom_ff;
      cfg.columns     = columns_eff;
      cfg.rows        = rows_eff;
      cfg.keep_inside = keep_inside_ff;
      cfg.box_ok      = (box_left_ff < box_right_ff) && (box_top_ff < box_bottom_ff) &&
                        (CMP_BITS'(box_right_ff) < columns_eff) &&
                        (CMP_BITS'(box_bottom_ff) < rows_eff);
   end

endmodule

`default_nettype wire

/* sv/rcc_divider.sv */
// Three-lane bit-serial divider forming rounded centroid coordinates.
`default_nettype none

module rcc_divider #(
   parameter int SUM_BITS = rcc_pkg::DEF_COORD_BITS + rcc_pkg::COUNT_BITS - 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [SUM_BITS-1:0]            sum_in [3],
   input  wire logic [rcc_pkg::COUNT_BITS-1:0] count_in,
   output logic [rcc_pkg::DATA_BITS-1:0]       quot_out [3],
   output logic                                busy
);
   import rcc_pkg::*;

   localparam int STEP_BITS = $clog2(SUM_BITS);

   logic [SUM_BITS-1:0]   dvd_ff [3];
   logic [SUM_BITS-1:0]   dvd_in [3];
   logic [COUNT_BITS-1:0] rem_ff [3];
   logic [COUNT_BITS-1:0] rem_in [3];
   logic                  neg_ff [3];
   logic                  neg_in [3];
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  prep_ff, prep_in;
   logic [COUNT_BITS:0]   rem_sh [3];
   logic [COUNT_BITS:0]   rem_diff [3];
   logic                  qbit [3];
   logic [SUM_BITS-1:0]   signed_q [3];

   always_comb begin
      cnt_in  = cnt_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      prep_in = prep_ff;
      for (int i = 0; i < 3; i++) begin
         dvd_in[i]   = dvd_ff[i];
         rem_in[i]   = rem_ff[i];
         neg_in[i]   = neg_ff[i];
         rem_sh[i]   = {rem_ff[i], dvd_ff[i][SUM_BITS-1]};
         rem_diff[i] = rem_sh[i] - {1'b0, cnt_ff};
         qbit[i]     = rem_sh[i] >= {1'b0, cnt_ff};
      end
      if (start) begin
         cnt_in  = count_in;
         step_in = '0;
         busy_in = 1'b1;
         prep_in = 1'b1;
         for (int i = 0; i < 3; i++) begin
            neg_in[i] = sum_in[i][SUM_BITS-1];
            dvd_in[i] = sum_in[i][SUM_BITS-1] ? (SUM_BITS'(0) - sum_in[i]) : sum_in[i];
            rem_in[i] = '0;
         end
      end else if (busy_ff && prep_ff) begin
         prep_in = 1'b0;
         for (int i = 0; i < 3; i++) begin
            dvd_in[i] = dvd_ff[i] + SUM_BITS'(cnt_ff[COUNT_BITS-1:1]);
         end
      end else if (busy_ff) begin
         for (int i = 0; i < 3; i++) begin
            rem_in[i] = qbit[i] ? rem_diff[i][COUNT_BITS-1:0] : rem_sh[i][COUNT_BITS-1:0];
            dvd_in[i] = {dvd_ff[i][SUM_BITS-2:0], qbit[i]};
         end
         step_in = step_ff + STEP_BITS'(1);
         if (step_ff == STEP_BITS'(SUM_BITS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         prep_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         prep_ff <= prep_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      for (int i = 0; i < 3; i++) begin
         dvd_ff[i] <= dvd_in[i];
         rem_ff[i] <= rem_in[i];
         neg_ff[i] <= neg_in[i];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         signed_q[i] = neg_ff[i] ? (SUM_BITS'(0) - dvd_ff[i]) : dvd_ff[i];
         quot_out[i] = signed_q[i][DATA_BITS-1:0];
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

/* sv/rcc_datapath.sv */
// Raster position, box test, coordinate sums and the result register.
`default_nettype none

module rcc_datapath #(
   parameter int MAX_COLUMNS = rcc_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = rcc_pkg::DEF_MAX_ROWS,
   parameter int COORD_BITS  = rcc_pkg::DEF_COORD_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire rcc_pkg::cfg_type               cfg,
   input  wire rcc_pkg::cmd_type               cmd,
   output rcc_pkg::status_type                 status,
   input  wire logic [rcc_pkg::DATA_BITS-1:0]  req_point_x,
   input  wire logic [rcc_pkg::DATA_BITS-1:0]  req_point_y,
   input  wire logic [rcc_pkg::DATA_BITS-1:0]  req_point_z,
   input  wire logic                           req_point_ok,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [1:0]                          rsp_result_kind,
   output logic [rcc_pkg::DATA_BITS-1:0]       rsp_out_x,
   output logic [rcc_pkg::DATA_BITS-1:0]       rsp_out_y,
   output logic [rcc_pkg::DATA_BITS-1:0]       rsp_out_z,
   output logic                                rsp_out_ok,
   output logic [rcc_pkg::COUNT_BITS-1:0]      rsp_valid_points,
   output logic                                rsp_frame_done
);
   import rcc_pkg::*;

   localparam int COL_BITS = $clog2(MAX_COLUMNS);
   localparam int ROW_BITS = $clog2(MAX_ROWS);
   localparam int SUM_BITS = COORD_BITS + COUNT_BITS - 1;

   logic [COL_BITS-1:0]   col_ff, col_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [SUM_BITS-1:0]   sum_ff [3];
   logic [SUM_BITS-1:0]   sum_in [3];
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] count_hold_ff, count_hold_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              kind_ff, kind_in;
   logic [DATA_BITS-1:0]  out_ff [3];
   logic [DATA_BITS-1:0]  out_in [3];
   logic                  out_ok_ff, out_ok_in;
   logic [COUNT_BITS-1:0] points_ff, points_in;
   logic                  done_ff, done_in;

   logic [CMP_BITS-1:0]   col_ext;
   logic [CMP_BITS-1:0]   row_ext;
   logic                  in_box;
   logic                  last_col;
   logic                  last;
   logic                  emit;
   logic                  point_valid;
   logic                  accumulate;
   logic                  out_free;
   logic [DATA_BITS-1:0]  coord [3];
   logic [SUM_BITS-1:0]   coord_wide [3];
   logic [DATA_BITS-1:0]  quot [3];
   logic                  div_busy;

   rcc_divider #(
      .SUM_BITS (SUM_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .sum_in   (sum_ff),
      .count_in (count_ff),
      .quot_out (quot),
      .busy     (div_busy)
   );

   always_comb begin
      col_ext  = CMP_BITS'(col_ff);
      row_ext  = CMP_BITS'(row_ff);
      in_box   = (col_ext >= CMP_BITS'(cfg.box_left)) && (col_ext < CMP_BITS'(cfg.box_right)) &&
                 (row_ext >= CMP_BITS'(cfg.box_top)) && (row_ext < CMP_BITS'(cfg.box_bottom));
      last_col = (col_ext + CMP_BITS'(1)) >= cfg.columns;
      last     = last_col && ((row_ext + CMP_BITS'(1)) >= cfg.rows);
      emit        = cfg.box_ok && (!cfg.keep_inside || in_box);
      point_valid = req_point_ok && (cfg.keep_inside || !in_box);
      accumulate  = cfg.box_ok && in_box && req_point_ok;
      coord_wide[0] = SUM_BITS'($signed(req_point_x[COORD_BITS-1:0]));
      coord_wide[1] = SUM_BITS'($signed(req_point_y[COORD_BITS-1:0]));
      coord_wide[2] = SUM_BITS'($signed(req_point_z[COORD_BITS-1:0]));
      for (int i = 0; i < 3; i++) begin
         coord[i] = coord_wide[i][DATA_BITS-1:0];
      end
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      count_in      = count_ff;
      count_hold_in = count_hold_ff;
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = sum_ff[i];
      end
      if (cmd.accept) begin
         if (accumulate) begin
            for (int i = 0; i < 3; i++) begin
               sum_in[i] = sum_ff[i] + coord_wide[i];
            end
            count_in = count_ff + COUNT_BITS'(1);
         end
         priority if (last) begin
            col_in = '0;
            row_in = '0;
         end else if (last_col) begin
            col_in = '0;
            row_in = row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
      if (cmd.div_start) begin
         count_hold_in = count_ff;
         count_in      = '0;
         for (int i = 0; i < 3; i++) begin
            sum_in[i] = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      out_ok_in    = out_ok_ff;
      points_in    = points_ff;
      done_in      = done_ff;
      for (int i = 0; i < 3; i++) begin
         out_in[i] = out_ff[i];
      end
      if (cmd.accept && emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_POINT;
         out_ok_in    = point_valid;
         points_in    = '0;
         done_in      = 1'b0;
         for (int i = 0; i < 3; i++) begin
            out_in[i] = point_valid ? coord[i] : '0;
         end
      end else if (cmd.cent_load) begin
         rsp_valid_in = 1'b1;
         done_in      = 1'b1;
         priority if (!cfg.box_ok) begin
            kind_in   = KIND_ERROR;
            out_ok_in = 1'b0;
            points_in = '0;
            for (int i = 0; i < 3; i++) begin
               out_in[i] = '0;
            end
         end else if (count_hold_ff == '0) begin
            kind_in   = KIND_CENTROID;
            out_ok_in = 1'b0;
            points_in = '0;
            for (int i = 0; i < 3; i++) begin
               out_in[i] = '0;
            end
         end else begin
            kind_in   = KIND_CENTROID;
            out_ok_in = 1'b1;
            points_in = count_hold_ff;
            for (int i = 0; i < 3; i++) begin
               out_in[i] = quot[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= sum_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      count_hold_ff <= count_hold_in;
      kind_ff       <= kind_in;
      out_ok_ff     <= out_ok_in;
      points_ff     <= points_in;
      done_ff       <= done_in;
      for (int i = 0; i < 3; i++) begin
         out_ff[i] <= out_in[i];
      end
   end

   always_comb begin
      status.last     = last;
      status.out_free = out_free;
      status.div_busy = div_busy;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_out_x        = out_ff[0];
   assign rsp_out_y        = out_ff[1];
   assign rsp_out_z        = out_ff[2];
   assign rsp_out_ok       = out_ok_ff;
   assign rsp_valid_points = points_ff;
   assign rsp_frame_done   = done_ff;

endmodule

`default_nettype wire

/* sv/rcc_ctrl.sv */
// Controller state machine sequencing points, centroid division and frame end.
`default_nettype none

module rcc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire rcc_pkg::status_type status,
   output rcc_pkg::cmd_type         cmd
);
   import rcc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd.accept    = 1'b0;
      cmd.div_start = 1'b0;
      cmd.cent_load = 1'b0;
      req_stall     = 1'b1;
      unique case (state_ff)
         ST_RUN: begin
            req_stall  = !status.out_free;
            cmd.accept = req_valid && status.out_free;
            if (cmd.accept && status.last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.cent_load = 1'b1;
               state_in      = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

`ifndef SYNTHESIS
   a_load_starts_divider: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |=> state_ff == ST_DIV && status.div_busy)
      else $error("Divider did not start after the sums were handed over.");

   a_divide_then_output: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && !status.div_busy |=> state_ff == ST_OUT)
      else $error("Finished division did not move on to the frame-end result.");

   a_frame_end_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.cent_load |-> status.out_free && !cmd.accept)
      else $error("Frame-end result loaded over a pending transaction.");
`endif

endmodule

`default_nettype wire

/* sv/roi_crop_centroid_core.sv */
// Top level of the region-of-interest crop with centroid of the valid box points.
// A point result sits in the output register in the cycle after its transaction is accepted.
// Points are taken at one per cycle while the result side keeps up.
// On the last point of a frame, input is stalled while a bit-serial divider forms the centroid,
// and longer while the result side stalls.
// Synchronous reset clears position, sums and the output valid flag, and restores the register defaults.
`default_nettype none

module roi_crop_centroid_core #(
   parameter int MAX_COLUMNS = rcc_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = rcc_pkg::DEF_MAX_ROWS,
   parameter int COORD_BITS  = rcc_pkg::DEF_COORD_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [rcc_pkg::DATA_BITS-1:0]      req_point_x,
   input  wire logic [rcc_pkg::DATA_BITS-1:0]      req_point_y,
   input  wire logic [rcc_pkg::DATA_BITS-1:0]      req_point_z,
   input  wire logic                               req_point_ok,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [1:0]                              rsp_result_kind,
   output logic [rcc_pkg::DATA_BITS-1:0]           rsp_out_x,
   output logic [rcc_pkg::DATA_BITS-1:0]           rsp_out_y,
   output logic [rcc_pkg::DATA_BITS-1:0]           rsp_out_z,
   output logic                                    rsp_out_ok,
   output logic [rcc_pkg::COUNT_BITS-1:0]          rsp_valid_points,
   output logic                                    rsp_frame_done,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [rcc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [rcc_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import rcc_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   rcc_csr #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rcc_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .COORD_BITS  (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .status           (status),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_z      (req_point_z),
      .req_point_ok     (req_point_ok),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .rsp_out_ok       (rsp_out_ok),
      .rsp_valid_points (rsp_valid_points),
      .rsp_frame_done   (rsp_frame_done)
   );

endmodule

`default_nettype wire
